/* sv/dhf_pkg.sv */
// ----------------------------------------------------------------------------
// dhf_pkg
// Shared constants and types of the decimal header framer.
// ----------------------------------------------------------------------------
`default_nettype none

package dhf_pkg;

  localparam int HEADER_BYTES = 64;
  localparam int FILL_W       = $clog2(HEADER_BYTES + 1);

  // function codes
  localparam logic [1:0] FUNC_HDR  = 2'd0;
  localparam logic [1:0] FUNC_NAME = 2'd1;
  localparam logic [1:0] FUNC_DATA = 2'd2;

  // frame characters
  localparam logic [7:0] CH_STX  = 8'h02;
  localparam logic [7:0] CH_ETX  = 8'h03;
  localparam logic [7:0] CH_BAR  = 8'h7C;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // field widths and saturation limits
  localparam int VAL_W = 17;
  localparam logic [9:0]  MAX_FNUM = 10'd999;
  localparam logic [9:0]  MAX_SNUM = 10'd999;
  localparam logic [13:0] MAX_CCNT = 14'd9999;
  localparam logic [16:0] MAX_TSZ  = 17'd99999;

  // digit buffer: positions in frame order, conversion runs from the last one down
  localparam int DIGITS = 15;
  localparam int DIG_W  = $clog2(DIGITS);
  localparam logic [DIG_W-1:0] K_FNUM = DIG_W'(2);
  localparam logic [DIG_W-1:0] K_SNUM = DIG_W'(5);
  localparam logic [DIG_W-1:0] K_CCNT = DIG_W'(9);
  localparam logic [DIG_W-1:0] K_TSZ  = DIG_W'(DIGITS - 1);

  // STX, fifteen digits, '|'
  localparam int HDR_LEN = DIGITS + 2;
  localparam int EMIT_W  = $clog2(HDR_LEN);
  localparam logic [EMIT_W-1:0] EMIT_LAST = EMIT_W'(HDR_LEN - 1);

  // divide by ten: q = (v * RECIP) >> RECIP_SH, exact for v < 2**VAL_W
  localparam int RECIP_W  = 20;
  localparam int RECIP_SH = 23;
  localparam logic [RECIP_W-1:0] RECIP = 20'd838861;

endpackage

`default_nettype wire

/* sv/dhf_if.sv */
// ----------------------------------------------------------------------------
// dhf_if
// Valid/ready channels of the decimal header framer.
// ----------------------------------------------------------------------------
`default_nettype none

interface dhf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [9:0]  file_number;
  logic [9:0]  sequence_number;
  logic [13:0] char_count;
  logic [16:0] total_size;
  logic [7:0]  data_byte;
  logic        is_last;

  modport source (output valid, func, file_number, sequence_number, char_count,
                  total_size, data_byte, is_last, input ready);
  modport sink   (input valid, func, file_number, sequence_number, char_count,
                  total_size, data_byte, is_last, output ready);
endinterface

interface dhf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       frame_end;

  modport source (output valid, out_byte, run_last, frame_end, input ready);
  modport sink   (input valid, out_byte, run_last, frame_end, output ready);
endinterface

`default_nettype wire

/* sv/dhf_div10.sv */
// ----------------------------------------------------------------------------
// dhf_div10
// Shared divide-by-ten unit: quotient and last decimal digit of a value.
// ----------------------------------------------------------------------------
`default_nettype none

module dhf_div10 (
  input  wire logic [dhf_pkg::VAL_W-1:0] val,
  output logic      [dhf_pkg::VAL_W-1:0] quo,
  output logic      [3:0]                rem
);
  import dhf_pkg::*;

  logic [VAL_W+RECIP_W-1:0] prod;
  logic [VAL_W-1:0]         quo10;

  assign prod  = {{RECIP_W{1'b0}}, val} * {{VAL_W{1'b0}}, RECIP};
  assign quo   = VAL_W'(prod >> RECIP_SH);
  assign quo10 = VAL_W'({quo, 3'b000} + {quo, 1'b0});
  // remainder is below ten by construction
  assign rem   = 4'(val - quo10);

endmodule

`default_nettype wire

/* sv/decimal_header_framer.sv */
// ----------------------------------------------------------------------------
// decimal_header_framer
// Byte framer with a decimal ASCII header, name field and padded header block.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  carries items: header fields (func 0), name bytes (func 1) and
//          payload bytes (func 2). out_ch carries frame bytes.
//   A header item converts its four fields to 15 digits, one digit per cycle
//   through a single divide-by-ten unit, then 17 bytes leave at one per
//   cycle while the receiver takes them. A name or payload byte is accepted,
//   then emitted; a name byte is dropped when it would leave no room for '|'.
//   The last name byte adds '|' and '0' padding up to HEADER_BYTES, the last
//   payload byte adds ETX. Items that cause nothing are only accepted.
//   in_ch.ready is high only while the sequencer is idle; it may accept while
//   the output register still holds an untaken byte.
//   A stalled receiver holds the output register and the sequencer waits.
//   Reset returns to the idle phase with an empty header and no output.
// ----------------------------------------------------------------------------
`default_nettype none

module decimal_header_framer (
  input wire logic clk,
  input wire logic rst_n,
  dhf_in_if.sink   in_ch,
  dhf_out_if.source out_ch
);
  import dhf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CONV, S_HDR, S_BYTE, S_BAR, S_PAD, S_ETX
  } state_t;

  typedef enum logic [1:0] {PH_IDLE, PH_NAME, PH_DATA} phase_t;

  state_t            st_r, st_nxt;
  phase_t            phase_r, phase_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [DIG_W-1:0]  k_r, k_nxt;
  logic [EMIT_W-1:0] e_r, e_nxt;
  logic [VAL_W-1:0]  w_r, w_nxt;
  logic [9:0]        fnum_r, fnum_nxt;
  logic [9:0]        snum_r, snum_nxt;
  logic [13:0]       ccnt_r, ccnt_nxt;
  logic [16:0]       tsz_r, tsz_nxt;
  logic [7:0]        db_r, db_nxt;
  logic              last_r, last_nxt;
  logic              is_name_r, is_name_nxt;
  logic [3:0]        digit_r [DIGITS];

  logic              ov_r, ov_nxt;
  logic [7:0]        ob_r, ob_nxt;
  logic              ol_r, ol_nxt;
  logic              oe_r, oe_nxt;

  logic              in_acc, slot_free;
  logic [VAL_W-1:0]  div_src, div_quo;
  logic [3:0]        div_rem;
  logic [FILL_W:0]   fill_p1, fill_p2;
  logic [EMIT_W-1:0] e_m1;
  logic [DIG_W-1:0]  rd_idx;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign slot_free = !ov_r || out_ch.ready;
  assign fill_p1   = {1'b0, fill_r} + (FILL_W+1)'(1);
  assign fill_p2   = {1'b0, fill_r} + (FILL_W+1)'(2);

  // each field restarts the shared unit from its latched value
  always_comb begin
    case (k_r)
      K_TSZ:   div_src = tsz_r;
      K_CCNT:  div_src = VAL_W'(ccnt_r);
      K_SNUM:  div_src = VAL_W'(snum_r);
      K_FNUM:  div_src = VAL_W'(fnum_r);
      default: div_src = w_r;
    endcase
  end

  dhf_div10 u_div10 (
    .val (div_src),
    .quo (div_quo),
    .rem (div_rem)
  );

  assign e_m1   = e_r - EMIT_W'(1);
  assign rd_idx = (e_r != '0 && e_r != EMIT_LAST) ? DIG_W'(e_m1) : '0;

  always_comb begin
    st_nxt      = st_r;
    phase_nxt   = phase_r;
    fill_nxt    = fill_r;
    k_nxt       = k_r;
    e_nxt       = e_r;
    w_nxt       = w_r;
    fnum_nxt    = fnum_r;
    snum_nxt    = snum_r;
    ccnt_nxt    = ccnt_r;
    tsz_nxt     = tsz_r;
    db_nxt      = db_r;
    last_nxt    = last_r;
    is_name_nxt = is_name_r;
    ov_nxt      = ov_r && !out_ch.ready;
    ob_nxt      = ob_r;
    ol_nxt      = ol_r;
    oe_nxt      = oe_r;

    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          db_nxt   = in_ch.data_byte;
          last_nxt = in_ch.is_last;
          case (in_ch.func)
            FUNC_HDR: begin
              fnum_nxt = (in_ch.file_number > MAX_FNUM) ? MAX_FNUM : in_ch.file_number;
              snum_nxt = (in_ch.sequence_number > MAX_SNUM) ? MAX_SNUM
                                                            : in_ch.sequence_number;
              ccnt_nxt = (in_ch.char_count > MAX_CCNT) ? MAX_CCNT : in_ch.char_count;
              tsz_nxt  = (in_ch.total_size > MAX_TSZ) ? MAX_TSZ : in_ch.total_size;
              k_nxt    = K_TSZ;
              st_nxt   = S_CONV;
            end
            FUNC_NAME: begin
              if (phase_r == PH_NAME) begin
                is_name_nxt = 1'b1;
                if (fill_p2 <= (FILL_W+1)'(HEADER_BYTES)) st_nxt = S_BYTE;
                else if (in_ch.is_last)                  st_nxt = S_BAR;
              end
            end
            FUNC_DATA: begin
              if (phase_r == PH_DATA) begin
                is_name_nxt = 1'b0;
                st_nxt      = S_BYTE;
              end
            end
            default: ;
          endcase
        end
      end
      S_CONV: begin
        w_nxt = div_quo;
        k_nxt = k_r - DIG_W'(1);
        if (k_r == '0) begin
          e_nxt  = '0;
          st_nxt = S_HDR;
        end
      end
      S_HDR: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          oe_nxt = 1'b0;
          ol_nxt = (e_r == EMIT_LAST);
          if (e_r == '0)            ob_nxt = CH_STX;
          else if (e_r == EMIT_LAST) ob_nxt = CH_BAR;
          else                      ob_nxt = CH_ZERO | {4'h0, digit_r[rd_idx]};
          e_nxt = e_r + EMIT_W'(1);
          if (e_r == EMIT_LAST) begin
            fill_nxt  = FILL_W'(HDR_LEN);
            phase_nxt = PH_NAME;
            st_nxt    = S_IDLE;
          end
        end
      end
      S_BYTE: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          ob_nxt = db_r;
          ol_nxt = !last_r;
          oe_nxt = 1'b0;
          if (is_name_r) begin
            fill_nxt = FILL_W'(fill_p1);
            st_nxt   = last_r ? S_BAR : S_IDLE;
          end else begin
            st_nxt = last_r ? S_ETX : S_IDLE;
          end
        end
      end
      S_BAR, S_PAD: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          ob_nxt   = (st_r == S_BAR) ? CH_BAR : CH_ZERO;
          oe_nxt   = 1'b0;
          ol_nxt   = (fill_p1 >= (FILL_W+1)'(HEADER_BYTES));
          fill_nxt = FILL_W'(fill_p1);
          if (fill_p1 >= (FILL_W+1)'(HEADER_BYTES)) begin
            phase_nxt = PH_DATA;
            st_nxt    = S_IDLE;
          end else begin
            st_nxt = S_PAD;
          end
        end
      end
      S_ETX: begin
        if (slot_free) begin
          ov_nxt    = 1'b1;
          ob_nxt    = CH_ETX;
          ol_nxt    = 1'b1;
          oe_nxt    = 1'b1;
          phase_nxt = PH_IDLE;
          fill_nxt  = '0;
          st_nxt    = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      phase_r <= PH_IDLE;
      fill_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      phase_r <= phase_nxt;
      fill_r  <= fill_nxt;
      ov_r    <= ov_nxt;
    end
    k_r       <= k_nxt;
    e_r       <= e_nxt;
    w_r       <= w_nxt;
    fnum_r    <= fnum_nxt;
    snum_r    <= snum_nxt;
    ccnt_r    <= ccnt_nxt;
    tsz_r     <= tsz_nxt;
    db_r      <= db_nxt;
    last_r    <= last_nxt;
    is_name_r <= is_name_nxt;
    ob_r      <= ob_nxt;
    ol_r      <= ol_nxt;
    oe_r      <= oe_nxt;
    if (st_r == S_CONV) digit_r[k_r] <= div_rem;
  end

  assign in_ch.ready      = (st_r == S_IDLE);
  assign out_ch.valid     = ov_r;
  assign out_ch.out_byte  = ob_r;
  assign out_ch.run_last  = ol_r;
  assign out_ch.frame_end = oe_r;

  a_etx_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oe_r) |-> (ol_r && ob_r == CH_ETX))
    else $error("frame end without closing ETX");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(HEADER_BYTES))
    else $error("header fill beyond header size");

  a_hdr_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.func == FUNC_HDR) |=> (st_r == S_CONV && k_r == K_TSZ))
    else $error("header item did not start conversion");

  a_pad_in_name: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_PAD || st_r == S_BAR) |-> (phase_r == PH_NAME))
    else $error("padding outside name phase");

endmodule

`default_nettype wire
